FILE: design/cim_pkg.sv
// ----------------------------------------------------------------------------
// cim_pkg
// types, widths and compare helpers shared by the candle inclusion merge block
// ----------------------------------------------------------------------------
`default_nettype none

package cim_pkg;

  localparam int PRICE_W = 32;
  localparam int POS_W   = 32;
  localparam int CNT_W   = 2;

  localparam logic [CNT_W-1:0] CNT_EMPTY = CNT_W'(0);
  localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(2);

  typedef logic [PRICE_W-1:0] price_t;
  typedef logic [POS_W-1:0]   pos_t;
  typedef logic [CNT_W-1:0]   cnt_t;

  localparam pos_t POS_MAX = '1;

  typedef struct packed {
    price_t bar_high;
    price_t bar_low;
    price_t bar_open;
    price_t bar_close;
  } bar_t;

  typedef struct packed {
    logic   replaced;
    price_t out_high;
    price_t out_low;
    price_t out_open;
    price_t out_close;
    pos_t   out_start;
    pos_t   out_end;
    pos_t   out_top;
  } res_t;

  typedef struct packed {
    price_t high;
    price_t low;
    price_t open_px;
    price_t close_px;
    pos_t   start_pos;
    pos_t   end_pos;
    pos_t   top_pos;
  } mbar_t;

  function automatic pos_t pos_inc(input pos_t p);
    pos_inc = (p == POS_MAX) ? POS_MAX : p + POS_W'(1);
  endfunction

  // bar a contains bar b
  function automatic logic holds(input price_t ah, input price_t al,
                                 input price_t bh, input price_t bl);
    holds = (ah >= bh) && (al <= bl);
  endfunction

  // bar a higher than or level with bar b
  function automatic logic above(input price_t ah, input price_t al,
                                 input price_t bh, input price_t bl);
    above = (ah >= bh) && (al >= bl);
  endfunction

  function automatic price_t pick(input logic up, input price_t a, input price_t b);
    if (up) begin
      pick = (a > b) ? a : b;
    end else begin
      pick = (a < b) ? a : b;
    end
  endfunction

endpackage

`default_nettype wire

FILE: design/candle_inclusion_merge.sv
// ----------------------------------------------------------------------------
// candle_inclusion_merge
// candlestick inclusion merging of a stream of raw price bars
// ----------------------------------------------------------------------------
// in_valid/in_ready carry one raw bar request (high, low, open, close) in
// unsigned ticks; out_valid/out_ready carry one result per raw bar: the
// current last merged bar and whether it was appended or replaced.
// a request taken lands in the input register; the merge runs once the
// output register is free or being read, and the result is registered
// into out_* together with the merged bar state.
// throughput: one request per cycle while out_ready stays high; the rate
// is set by the merge loop through the last merged bar register.
// reset (rst_n low, synchronous) empties both registers and clears the
// merged bar, the previous bar, the count and the position counter.
// when the receiver holds out_ready low the result stays put, the input
// register fills and in_ready then drops until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module candle_inclusion_merge
  import cim_pkg::*;
(
  input  wire  clk,
  input  wire  rst_n,
  input  wire  in_valid,
  output logic in_ready,
  input  bar_t in_bar,
  output logic out_valid,
  input  wire  out_ready,
  output res_t out_result
);

  logic bar_valid;
  bar_t bar;
  logic fire;
  res_t res;
  logic out_valid_r;
  logic out_valid_nxt;
  res_t out_result_r;

  assign fire = bar_valid && (!out_valid_r || out_ready);

  cim_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_bar    (in_bar),
    .take      (fire),
    .bar_valid (bar_valid),
    .bar       (bar)
  );

  cim_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .bar   (bar),
    .res   (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_result_r <= res;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

endmodule

`default_nettype wire

FILE: design/cim_in_reg.sv
// ----------------------------------------------------------------------------
// cim_in_reg
// input register holding one raw bar request ahead of the merge core
// ----------------------------------------------------------------------------
`default_nettype none

module cim_in_reg
  import cim_pkg::*;
(
  input  wire  clk,
  input  wire  rst_n,
  input  wire  in_valid,
  output logic in_ready,
  input  bar_t in_bar,
  input  wire  take,
  output logic bar_valid,
  output bar_t bar
);

  logic valid_r;
  logic valid_nxt;
  bar_t bar_r;

  assign in_ready  = !valid_r || take;
  assign bar_valid = valid_r;
  assign bar       = bar_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      bar_r <= in_bar;
    end
  end

endmodule

`default_nettype wire

FILE: design/cim_core.sv
// ----------------------------------------------------------------------------
// cim_core
// merged bar state and the single pass inclusion merge
// ----------------------------------------------------------------------------
`default_nettype none

module cim_core
  import cim_pkg::*;
(
  input  wire  clk,
  input  wire  rst_n,
  input  wire  fire,
  input  bar_t bar,
  output res_t res
);

  mbar_t  last_r, last_nxt;
  price_t prev_high_r, prev_high_nxt;
  price_t prev_low_r, prev_low_nxt;
  cnt_t   cnt_r, cnt_nxt;
  pos_t   next_pos_r, next_pos_nxt;

  logic   contain;
  logic   up;
  price_t m_high;
  price_t m_low;

  always_comb begin
    last_nxt      = last_r;
    prev_high_nxt = prev_high_r;
    prev_low_nxt  = prev_low_r;
    cnt_nxt       = cnt_r;
    next_pos_nxt  = pos_inc(next_pos_r);

    contain = (cnt_r != CNT_EMPTY) &&
              (holds(bar.bar_high, bar.bar_low, last_r.high, last_r.low) ||
               holds(last_r.high, last_r.low, bar.bar_high, bar.bar_low));

    if (cnt_r == CNT_FULL) begin
      up = above(last_r.high, last_r.low, prev_high_r, prev_low_r);
    end else begin
      up = !above(last_r.high, last_r.low, bar.bar_high, bar.bar_low);
    end

    m_high = pick(up, last_r.high, bar.bar_high);
    m_low  = pick(up, last_r.low, bar.bar_low);

    if (contain) begin
      last_nxt.high     = m_high;
      last_nxt.low      = m_low;
      last_nxt.open_px  = pick(up, last_r.open_px, bar.bar_open);
      last_nxt.close_px = pick(up, last_r.close_px, bar.bar_close);
      if (holds(bar.bar_high, bar.bar_low, m_high, m_low)) begin
        last_nxt.top_pos = pos_inc(last_r.end_pos);
      end
      last_nxt.end_pos = next_pos_r;
    end else begin
      prev_high_nxt      = last_r.high;
      prev_low_nxt       = last_r.low;
      last_nxt.high      = bar.bar_high;
      last_nxt.low       = bar.bar_low;
      last_nxt.open_px   = bar.bar_open;
      last_nxt.close_px  = bar.bar_close;
      last_nxt.start_pos = next_pos_r;
      last_nxt.end_pos   = next_pos_r;
      last_nxt.top_pos   = next_pos_r;
      if (cnt_r != CNT_FULL) begin
        cnt_nxt = cnt_r + CNT_ONE;
      end
    end

    res.replaced  = contain;
    res.out_high  = last_nxt.high;
    res.out_low   = last_nxt.low;
    res.out_open  = last_nxt.open_px;
    res.out_close = last_nxt.close_px;
    res.out_start = last_nxt.start_pos;
    res.out_end   = last_nxt.end_pos;
    res.out_top   = last_nxt.top_pos;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r      <= '0;
      prev_high_r <= '0;
      prev_low_r  <= '0;
      cnt_r       <= CNT_EMPTY;
      next_pos_r  <= '0;
    end else if (fire) begin
      last_r      <= last_nxt;
      prev_high_r <= prev_high_nxt;
      prev_low_r  <= prev_low_nxt;
      cnt_r       <= cnt_nxt;
      next_pos_r  <= next_pos_nxt;
    end
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != CNT_W'(3))
    else $error("merged bar count out of range");

  a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> next_pos_r == $past(pos_inc(next_pos_r)))
    else $error("position did not advance by one");

  a_merge_keeps_start: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res.replaced |=> last_r.start_pos == $past(last_r.start_pos))
    else $error("merge moved the start position");

  a_append_marks: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !res.replaced |-> res.out_start == next_pos_r &&
                               res.out_end == next_pos_r &&
                               res.out_top == next_pos_r)
    else $error("appended bar positions inconsistent");
`endif

endmodule

`default_nettype wire

FILE: verif/candle_inclusion_merge_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// candle_inclusion_merge_test
// self-checking bench for the candlestick inclusion merge block
// ----------------------------------------------------------------------------
// raw bar requests go in over a valid/ready channel and every result is
// compared with a model of the merge held in this bench. a short table of
// hand-picked bars comes first (first bar, inside and outside bars in both
// directions, inverted bars, price extremes), then random bars shaped as a
// drifting market with some full-range and inverted noise, under two
// patterns of sender and receiver stalls and one pattern with none.
// ----------------------------------------------------------------------------

module candle_inclusion_merge_test;
  import cim_pkg::*;

  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned RANDOM_BARS = 200;
  localparam int unsigned PLAN_LEN    = 17;
  localparam int unsigned SB_DEPTH    = 16;

  typedef struct packed {
    bar_t bar;
    logic typed;
    res_t want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  bar_t in_bar = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  res_t out_result;

  int unsigned send_idle = 36;
  int unsigned take_idle = 87;

  // model state
  mbar_t tip = '0;
  price_t prior_high = '0;
  price_t prior_low = '0;
  cnt_t bar_count = CNT_EMPTY;
  pos_t seq_pos = '0;

  // results still owed by the block, oldest at sb_rd_n
  res_t sb_res [SB_DEPTH];
  int unsigned sb_wr_n = 0;
  int unsigned sb_rd_n = 0;
  res_t want_r;
  int unsigned bad_results = 0;
  int unsigned merges_seen = 0;
  int unsigned appends_seen = 0;
  int unsigned bars_taken = 0;
  int unsigned quiet_cycles = 0;

  plan_row_t plan [PLAN_LEN] = '{
    '{'{32'd100, 32'd50, 32'd60, 32'd90}, 1'b1,
      '{1'b0, 32'd100, 32'd50, 32'd60, 32'd90, 32'd0, 32'd0, 32'd0}},
    '{'{32'd90, 32'd60, 32'd70, 32'd80}, 1'b0, '0},
    '{'{32'd120, 32'd40, 32'd10, 32'd200}, 1'b0, '0},
    '{'{32'd300, 32'd250, 32'd260, 32'd290}, 1'b0, '0},
    '{'{32'd280, 32'd260, 32'd255, 32'd300}, 1'b0, '0},
    '{'{32'd200, 32'd150, 32'd180, 32'd160}, 1'b0, '0},
    '{'{32'd190, 32'd160, 32'd170, 32'd165}, 1'b0, '0},
    '{'{32'd210, 32'd140, 32'd150, 32'd200}, 1'b0, '0},
    '{'{32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'd0}, 1'b0, '0},
    '{'{32'hFFFF_FFFF, 32'd0, 32'd0, 32'hFFFF_FFFF}, 1'b0, '0},
    '{'{32'd0, 32'd0, 32'd0, 32'd0}, 1'b0, '0},
    '{'{32'd10, 32'd500, 32'd20, 32'd30}, 1'b0, '0},
    '{'{32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0}, 1'b0, '0},
    '{'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b0, '0},
    '{'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b0, '0},
    '{'{32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555}, 1'b0, '0},
    '{'{32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA}, 1'b0, '0}
  };

  candle_inclusion_merge dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_bar     (in_bar),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_result (out_result)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic price_t bound(input logic rising, input price_t a, input price_t b);
    if (rising) begin
      return (a >= b) ? a : b;
    end
    return (a <= b) ? a : b;
  endfunction

  // fold one raw bar into the last merged bar and return the result it gives
  function automatic res_t fold_bar(input bar_t b);
    pos_t pos;
    logic rising;
    logic wraps;
    pos = seq_pos;
    seq_pos = (seq_pos == '1) ? seq_pos : seq_pos + POS_W'(1);
    wraps = (bar_count != CNT_EMPTY) &&
            ((b.bar_high >= tip.high && b.bar_low <= tip.low) ||
             (tip.high >= b.bar_high && tip.low <= b.bar_low));
    if (wraps) begin
      if (bar_count == CNT_FULL) begin
        rising = (tip.high >= prior_high) && (tip.low >= prior_low);
      end else begin
        rising = !((tip.high >= b.bar_high) && (tip.low >= b.bar_low));
      end
      tip.high     = bound(rising, tip.high, b.bar_high);
      tip.low      = bound(rising, tip.low, b.bar_low);
      tip.open_px  = bound(rising, tip.open_px, b.bar_open);
      tip.close_px = bound(rising, tip.close_px, b.bar_close);
      if (b.bar_high >= tip.high && b.bar_low <= tip.low) begin
        tip.top_pos = (tip.end_pos == '1) ? tip.end_pos : tip.end_pos + POS_W'(1);
      end
      tip.end_pos = pos;
    end else begin
      prior_high = tip.high;
      prior_low  = tip.low;
      tip = '{b.bar_high, b.bar_low, b.bar_open, b.bar_close, pos, pos, pos};
      if (bar_count != CNT_FULL) begin
        bar_count = bar_count + CNT_ONE;
      end
    end
    return '{wraps, tip.high, tip.low, tip.open_px, tip.close_px,
             tip.start_pos, tip.end_pos, tip.top_pos};
  endfunction

  task automatic offer_bar(input bar_t b, input logic typed, input res_t want);
    res_t folded;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_bar   <= b;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    folded = fold_bar(b);
    sb_res[sb_wr_n[3:0]] = typed ? want : folded;
    sb_wr_n++;
    bars_taken++;
  endtask

  // result checker and receiver stalls
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (out_result.replaced) begin
        merges_seen++;
      end else begin
        appends_seen++;
      end
      if (sb_wr_n == sb_rd_n) begin
        bad_results++;
        if (bad_results <= 10) begin
          $display("unexpected result: %h", out_result);
        end
      end else begin
        want_r = sb_res[sb_rd_n[3:0]];
        sb_rd_n++;
        if (out_result.replaced !== want_r.replaced ||
            out_result.out_high !== want_r.out_high ||
            out_result.out_low !== want_r.out_low ||
            out_result.out_open !== want_r.out_open ||
            out_result.out_close !== want_r.out_close ||
            out_result.out_start !== want_r.out_start ||
            out_result.out_end !== want_r.out_end ||
            out_result.out_top !== want_r.out_top) begin
          bad_results++;
          if (bad_results <= 10) begin
            $display("mismatch at %0t: rep/high/low/open/close/start/end/top", $realtime);
            $display("  exp %b %h %h %h %h %h %h %h", want_r.replaced, want_r.out_high,
                     want_r.out_low, want_r.out_open, want_r.out_close,
                     want_r.out_start, want_r.out_end, want_r.out_top);
            $display("  got %b %h %h %h %h %h %h %h", out_result.replaced,
                     out_result.out_high, out_result.out_low, out_result.out_open,
                     out_result.out_close, out_result.out_start, out_result.out_end,
                     out_result.out_top);
          end
        end
      end
    end
    out_ready <= ($urandom_range(99) >= take_idle);
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("stalled for %0d cycles with %0d results outstanding",
               quiet_cycles, sb_wr_n - sb_rd_n);
      $display("candle_inclusion_merge_test: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    price_t level;
    price_t ha;
    price_t hb;
    price_t h;
    price_t l;
    int unsigned mode;
    int unsigned step;
    bar_t b;
    level = 32'h8000_0000;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < PLAN_LEN; i++) begin
      offer_bar(plan[i].bar, plan[i].typed, plan[i].want);
    end

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle = 36;
          take_idle = 87;
        end
        1: begin
          send_idle = 87;
          take_idle = 36;
        end
        default: begin
          send_idle = 0;
          take_idle = 0;
        end
      endcase
      for (int n = 0; n < RANDOM_BARS; n++) begin
        mode = $urandom_range(99);
        if (mode < 70) begin
          // drifting market, small ranges so inside and outside bars are common
          step = $urandom_range(300);
          level = $urandom_range(1) ? level + step : level - step;
          if (level < 32'd1000) begin
            level = 32'd1000;
          end
          if (level > 32'hFFFF_F000) begin
            level = 32'hFFFF_F000;
          end
          h = level + $urandom_range(200);
          l = level - $urandom_range(200);
          b = '{h, l, $urandom_range(h, l), $urandom_range(h, l)};
        end else if (mode < 85) begin
          ha = $urandom;
          hb = $urandom;
          b = '{(ha >= hb) ? ha : hb, (ha >= hb) ? hb : ha, $urandom, $urandom};
        end else if (mode < 95) begin
          // inverted bar, low above high
          ha = $urandom;
          hb = $urandom;
          b = '{(ha >= hb) ? hb : ha, (ha >= hb) ? ha : hb, $urandom, $urandom};
        end else begin
          b.bar_high  = $urandom_range(1) ? 32'hFFFF_FFFF : $urandom;
          b.bar_low   = $urandom_range(1) ? 32'd0 : $urandom;
          b.bar_open  = $urandom_range(1) ? 32'd0 : 32'hFFFF_FFFF;
          b.bar_close = $urandom_range(1) ? 32'hFFFF_FFFF : 32'd0;
        end
        offer_bar(b, 1'b0, '0);
      end
    end
    in_valid <= 1'b0;

    while (sb_wr_n != sb_rd_n) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);

    $display("%0d bars taken (%0d from the table, rest random under three stall patterns)",
             bars_taken, PLAN_LEN);
    $display("%0d merges and %0d appends seen, %0d bad results",
             merges_seen, appends_seen, bad_results);
    if (bad_results == 0 && sb_wr_n == sb_rd_n) begin
      $display("candle_inclusion_merge_test: clean");
    end else begin
      $display("candle_inclusion_merge_test: errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/cim_pkg.sv
design/cim_in_reg.sv
design/cim_core.sv
design/candle_inclusion_merge.sv
verif/candle_inclusion_merge_test.sv
